>>> rtl/mcr_pkg.sv
// Shared types and constants for the midpoint circle rasterizer.
package mcr_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned PixW   = 13;
  localparam int unsigned RadW   = 10;
  localparam int unsigned DecW   = 16;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 32;

  // Decision update terms: 5-4r at start, (2(x-y)+5)*4 and (2x+3)*4 per step.
  localparam logic [DecW-1:0] DecInit     = 16'd5;
  localparam logic [DecW-1:0] DecDiagTerm = 16'd20;
  localparam logic [DecW-1:0] DecAxisTerm = 16'd12;

  localparam logic [1:0] AxisLastSlot = 2'd3;
  localparam logic [2:0] OctLastSlot  = 3'd7;
  localparam logic [2:0] OctFirstSlot = 3'd0;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } mcr_cmd_e;

  typedef struct packed {
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic [RadW-1:0]          offset_x;
    logic [RadW-1:0]          offset_y;
    logic [DecW-1:0]          decision;
    logic [2:0]               mirror_slot;
    logic                     axis_phase;
    logic                     active;
  } mcr_state_t;

  typedef struct packed {
    logic                   valid_res;
    logic signed [PixW-1:0] pixel_x;
    logic signed [PixW-1:0] pixel_y;
    logic                   last;
  } mcr_pixel_t;

endpackage

>>> rtl/mcr_step.sv
// Combinational step: one request against the tracer state gives one pixel and the next state.
module mcr_step (
  input  mcr_pkg::mcr_state_t              state_i,
  input  mcr_pkg::mcr_cmd_e                cmd_i,
  input  logic signed [mcr_pkg::CoordW-1:0] center_x_i,
  input  logic signed [mcr_pkg::CoordW-1:0] center_y_i,
  input  logic [mcr_pkg::RadW-1:0]          radius_i,
  output mcr_pkg::mcr_state_t              state_o,
  output mcr_pkg::mcr_pixel_t              pixel_o
);
  import mcr_pkg::*;

  mcr_state_t          cur;
  mcr_state_t          nxt;
  logic [RadW-1:0]     x;
  logic [RadW-1:0]     y;
  logic [DecW-1:0]     d;
  logic [RadW-1:0]     pa;
  logic [RadW-1:0]     pb;
  logic signed [PixW-1:0] a;
  logic signed [PixW-1:0] b;
  logic signed [PixW-1:0] mag;
  logic [1:0]          s2;
  logic                fin;

  always_comb begin
    cur = state_i;
    // Start drops any running circle and loads a fresh one.
    if (cmd_i == CMD_START) begin
      cur.center_x    = center_x_i;
      cur.center_y    = center_y_i;
      cur.offset_x    = '0;
      cur.offset_y    = radius_i;
      cur.decision    = DecInit - {4'b0000, radius_i, 2'b00};
      cur.mirror_slot = '0;
      cur.axis_phase  = 1'b1;
      cur.active      = 1'b1;
    end

    nxt = cur;
    x   = cur.offset_x;
    y   = cur.offset_y;
    d   = cur.decision;
    pa  = '0;
    pb  = '0;
    a   = '0;
    b   = '0;
    s2  = cur.mirror_slot[1:0];
    mag = $signed({3'b000, cur.offset_y});
    fin = 1'b0;
    pixel_o = '0;

    if (cur.active) begin
      if (cur.axis_phase) begin
        if (!s2[1]) begin
          b = s2[0] ? -mag : mag;
        end else begin
          a = s2[0] ? -mag : mag;
        end
        fin = (s2 == AxisLastSlot) && !(cur.offset_y > cur.offset_x);
        if (s2 == AxisLastSlot) begin
          nxt.axis_phase  = 1'b0;
          nxt.mirror_slot = OctFirstSlot;
        end else begin
          nxt.mirror_slot = {1'b0, s2} + 3'd1;
        end
      end else begin
        // Advance the decision once per group of eight mirrored points.
        if (cur.mirror_slot == OctFirstSlot) begin
          if (!d[DecW-1]) begin
            d = d + (({6'b0, x} - {6'b0, y}) << 3) + DecDiagTerm;
            x = x + 1'b1;
            y = y - 1'b1;
          end else begin
            d = d + ({6'b0, x} << 3) + DecAxisTerm;
            x = x + 1'b1;
          end
        end
        nxt.offset_x = x;
        nxt.offset_y = y;
        nxt.decision = d;
        pa = cur.mirror_slot[2] ? y : x;
        pb = cur.mirror_slot[2] ? x : y;
        a  = cur.mirror_slot[0] ? -$signed({3'b000, pa}) : $signed({3'b000, pa});
        b  = cur.mirror_slot[1] ? -$signed({3'b000, pb}) : $signed({3'b000, pb});
        fin = (cur.mirror_slot == OctLastSlot) && !(y > x);
        nxt.mirror_slot = cur.mirror_slot + 3'd1;
      end
      if (fin) begin
        nxt.active = 1'b0;
      end
      pixel_o.valid_res = 1'b1;
      pixel_o.pixel_x   = $signed({cur.center_x[CoordW-1], cur.center_x}) + a;
      pixel_o.pixel_y   = $signed({cur.center_y[CoordW-1], cur.center_y}) + b;
      pixel_o.last      = fin;
    end
    state_o = nxt;
  end

endmodule

>>> rtl/midpoint_circle_rasterizer.sv
// Top level of the midpoint circle rasterizer: request register, tracer state, pixel register.
//
// Usage: each request on the slave stream gives exactly one result on the master stream.
// s_axis_tuser selects the command: start a circle (center and radius in s_axis_tdata)
// or ask for the next pixel of the running circle. Pixels come out as the four axis
// points, then eight mirrored points per decision step; m_axis_tlast marks the final
// pixel. A next request with no circle running returns m_axis_tuser = 0 and zero data.
// A start while a circle runs drops it and begins the new one.
// The request register holds an accepted request; the step logic then updates the tracer state
// and the pixel register captures the result, which is then offered on the master stream.
// Throughput: one request per cycle while m_axis_tready does not stall it, set by the step
// logic that updates the tracer state between the two registers.
// Stall: when m_axis_tready is low the pixel register holds, the request register
// fills, and s_axis_tready drops; no request is lost or repeated.
// Reset: rst_ni clears both registers' valid flags and the tracer state (idle).
module midpoint_circle_rasterizer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [11:0] center_x, [23:12] center_y, [33:24] radius, [39:34] zero
  input  logic [mcr_pkg::InDataW-1:0]    s_axis_tdata,
  // [0] cmd
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [12:0] pixel_x, [25:13] pixel_y, [31:26] zero
  output logic [mcr_pkg::OutDataW-1:0]   m_axis_tdata,
  // [0] valid_res
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);
  import mcr_pkg::*;

  logic                  req_valid_q;
  logic                  req_valid_d;
  logic [InDataW-1:0]    req_data_q;
  logic                  req_cmd_q;
  logic                  res_valid_q;
  logic                  res_valid_d;
  mcr_pixel_t            res_q;
  mcr_state_t            state_q;
  mcr_state_t            state_d;
  mcr_pixel_t            pixel;
  logic                  out_free;
  logic                  step_en;
  logic                  s_fire;

  assign out_free      = !res_valid_q || m_axis_tready;
  assign step_en       = req_valid_q && out_free;
  assign s_axis_tready = !req_valid_q || out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign req_valid_d   = s_fire || (req_valid_q && !out_free);
  assign res_valid_d   = step_en || (res_valid_q && !m_axis_tready);

  mcr_step u_step (
    .state_i    (state_q),
    .cmd_i      (mcr_cmd_e'(req_cmd_q)),
    .center_x_i (req_data_q[11:0]),
    .center_y_i (req_data_q[23:12]),
    .radius_i   (req_data_q[33:24]),
    .state_o    (state_d),
    .pixel_o    (pixel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      req_valid_q <= req_valid_d;
      res_valid_q <= res_valid_d;
      if (step_en) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers: request data loads on accept, the pixel on each step; both hold otherwise.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      req_data_q <= s_axis_tdata;
      req_cmd_q  <= s_axis_tuser;
    end
    if (step_en) begin
      res_q <= pixel;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {6'b000000, res_q.pixel_y, res_q.pixel_x};
  assign m_axis_tuser  = res_q.valid_res;
  assign m_axis_tlast  = res_q.last;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the midpoint circle rasterizer stream block.
`timescale 1ns / 100ps

module tb_top;
  import mcr_pkg::*;

  localparam int StallLimit = 5000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [11:0] center_x, [23:12] center_y, [33:24] radius, [39:34] zero
  logic [InDataW-1:0]  s_axis_tdata = '0;
  // [0] cmd
  logic                s_axis_tuser = CMD_NEXT;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [12:0] pixel_x, [25:13] pixel_y, [31:26] zero
  logic [OutDataW-1:0] m_axis_tdata;
  // [0] valid_res
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  mcr_pixel_t pending_pixels[$];

  // Tracer state mirrored from the block
  logic signed [CoordW-1:0] trace_cx;
  logic signed [CoordW-1:0] trace_cy;
  int                       trace_x;
  int                       trace_y;
  logic signed [DecW-1:0]   trace_dec;
  int                       trace_slot;
  bit                       trace_axis;
  bit                       trace_busy;

  midpoint_circle_rasterizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Next pixel of the traced circle for one accepted request.
  function automatic mcr_pixel_t trace_pixel(input mcr_cmd_e cmd,
                                             input logic signed [CoordW-1:0] cx,
                                             input logic signed [CoordW-1:0] cy,
                                             input logic [RadW-1:0] r);
    mcr_pixel_t px;
    int a;
    int b;
    int s;
    int sum;
    bit fin;
    px = '0;
    if (cmd == CMD_START) begin
      trace_cx   = cx;
      trace_cy   = cy;
      trace_x    = 0;
      trace_y    = int'(r);
      trace_dec  = DecW'(5 - 4 * int'(r));
      trace_slot = 0;
      trace_axis = 1'b1;
      trace_busy = 1'b1;
    end else if (!trace_busy) begin
      return px;
    end
    s = trace_slot;
    if (trace_axis) begin
      s = s & 3;
      if (s < 2) begin
        a = 0;
        b = (s & 1) ? -trace_y : trace_y;
      end else begin
        b = 0;
        a = (s & 1) ? -trace_y : trace_y;
      end
      fin = (s == 3) && !(trace_y > trace_x);
      if (s == 3) begin
        trace_axis = 1'b0;
        trace_slot = 0;
      end else begin
        trace_slot = s + 1;
      end
    end else begin
      // Step the decision value on the first of each group of eight
      if (s == 0) begin
        if (trace_dec >= 0) begin
          sum = int'(trace_dec) + ((trace_x - trace_y) * 2 + 5) * 4;
          trace_y = trace_y - 1;
        end else begin
          sum = int'(trace_dec) + (trace_x * 2 + 3) * 4;
        end
        trace_dec = DecW'(sum);
        trace_x = trace_x + 1;
      end
      a = (s < 4) ? trace_x : trace_y;
      b = (s < 4) ? trace_y : trace_x;
      if (s & 1) a = -a;
      if (s & 2) b = -b;
      fin = (s == 7) && !(trace_y > trace_x);
      trace_slot = (s + 1) & 7;
    end
    if (fin) trace_busy = 1'b0;
    px.valid_res = 1'b1;
    px.pixel_x   = PixW'(int'(trace_cx) + a);
    px.pixel_y   = PixW'(int'(trace_cy) + b);
    px.last      = fin;
    return px;
  endfunction

  // Send one request; report whether its pixel closes the circle.
  task automatic send_request(input mcr_cmd_e cmd, input logic [CoordW-1:0] cx,
                              input logic [CoordW-1:0] cy, input logic [RadW-1:0] r,
                              output bit closes);
    mcr_pixel_t px;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {6'b0, r, cy, cx};
    do @(posedge clk_i); while (!s_axis_tready);
    px = trace_pixel(cmd, cx, cy, r);
    pending_pixels.push_back(px);
    closes = px.last;
    @(negedge clk_i);
  endtask

  task automatic send_next(output bit closes);
    send_request(CMD_NEXT, CoordW'($urandom()), CoordW'($urandom()), RadW'($urandom()),
                 closes);
  endtask

  task automatic report_if_diff(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Zero radius: four axis pixels on the center, then a next with no circle running.
  task automatic test_zero_radius();
    bit closes;
    send_request(CMD_START, '0, '0, '0, closes);
    repeat (4) send_next(closes);
  endtask

  // Corner centers at full radius, restarting before the circle completes.
  task automatic test_extremes_and_restart();
    bit closes;
    send_request(CMD_START, 12'h7FF, 12'h800, 10'h3FF, closes);
    repeat (3) send_next(closes);
    send_request(CMD_START, 12'h800, 12'h7FF, 10'h3FF, closes);
    repeat (3) send_next(closes);
  endtask

  // Unit circle run to its final pixel: axis points and one octant step.
  task automatic test_unit_circle();
    bit closes;
    send_request(CMD_START, 12'hFFF, 12'hFFF, 10'd1, closes);
    while (!closes) send_next(closes);
  endtask

  task automatic test_random_circles(input int count);
    int sent;
    int pick;
    int steps;
    bit closes;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // Well-formed circle, sometimes cut short
        send_request(CMD_START, CoordW'($urandom()), CoordW'($urandom()),
                     RadW'($urandom_range(24)), closes);
        sent++;
        steps = ($urandom_range(6) == 0) ? $urandom_range(1, 40) : 1 << 20;
        while (!closes && steps > 0) begin
          send_next(closes);
          sent++;
          steps--;
        end
        if (closes && $urandom_range(4) == 0) begin
          send_next(closes);
          sent++;
        end
      end else if (pick < 85) begin
        // Large radius, dropped by the next start
        send_request(CMD_START, CoordW'($urandom()), CoordW'($urandom()),
                     RadW'($urandom()), closes);
        sent++;
        steps = $urandom_range(60);
        while (!closes && steps > 0) begin
          send_next(closes);
          sent++;
          steps--;
        end
      end else begin
        send_request(mcr_cmd_e'($urandom_range(1)), CoordW'($urandom()),
                     CoordW'($urandom()), RadW'($urandom()), closes);
        sent++;
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    mcr_pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d", $time,
                 $signed(m_axis_tdata[12:0]), $signed(m_axis_tdata[25:13]));
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        report_if_diff("valid_res", want.valid_res, m_axis_tuser);
        report_if_diff("pixel_x", want.pixel_x, $signed(m_axis_tdata[12:0]));
        report_if_diff("pixel_y", want.pixel_y, $signed(m_axis_tdata[25:13]));
        report_if_diff("last", want.last, m_axis_tlast);
      end
    end
  end

  // End the run when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    trace_busy = 1'b0;
    trace_axis = 1'b0;
    trace_slot = 0;
    trace_x    = 0;
    trace_y    = 0;
    trace_dec  = '0;
    trace_cx   = '0;
    trace_cy   = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 34;
    recv_idle_pct = 67;
    test_zero_radius();
    test_extremes_and_restart();
    test_unit_circle();
    test_random_circles(430);

    send_idle_pct = 67;
    recv_idle_pct = 34;
    test_random_circles(450);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_circles(450);

    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
